// ===== src/cti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cti_pkg
// Shared constants and pipeline word types for the circle time-of-impact
// engine.
// ----------------------------------------------------------------------------
package cti_pkg;

   // Default fixed-point formats.
   localparam int POS_FRAC_BITS_DEF  = 16;
   localparam int TIME_FRAC_BITS_DEF = 24;

   // Configuration register map.
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SNAP_WINDOW = 8'd1;
   localparam logic [CSR_DATA_W-1:0] EPSILON_RESET     = 24'd17;
   localparam logic [CSR_DATA_W-1:0] SNAP_WINDOW_RESET = 24'd838861;

   // Internal widths, set by the fixed field widths.
   localparam int A_W    = 56;   // |v|^2
   localparam int UB_W   = 57;   // rp.v when positive
   localparam int D_W    = 58;   // |p2 - s2|
   localparam int DISC_W = 116;  // discriminant
   localparam int ROOT_W = 58;   // floor sqrt of the discriminant
   localparam int SREM_W = 62;   // square root remainder
   localparam int Q_W    = 33;   // quotient bits that can still hit
   localparam int TIME_W = 32;

   // Word carried through the square root stages.
   typedef struct packed {
      logic              valid;
      logic              nohit;
      logic [TIME_W-1:0] maxt;
      logic [UB_W-1:0]   ub;
      logic [A_W-1:0]    a;
      logic [ROOT_W-1:0] root;
      logic [SREM_W-1:0] rem;
      logic [DISC_W-1:0] n;
   } sq_stage_type;

   // Word carried through the divider stages.
   typedef struct packed {
      logic              valid;
      logic              nohit;
      logic              neg;
      logic [TIME_W-1:0] maxt;
      logic [A_W-1:0]    a;
      logic [Q_W-1:0]    q;
      logic [A_W-1:0]    rem;
      logic [Q_W-1:0]    lo;
   } dv_stage_type;

endpackage

// ===== src/circle_time_of_impact.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_time_of_impact
// Earliest contact time of a moving circle against a stationary circle.
// ----------------------------------------------------------------------------
// Usage:
//   A query word is taken at every rising edge where start is high and busy
//   is low. busy is always low, so one query can be issued every cycle.
//   Each query yields exactly one result word, shown on rsp_hit and
//   rsp_contact_time for one cycle while rsp_strobe is high. The receiver
//   cannot stall, and none is needed: results leave in issue order.
//   A query passes through the setup and wide multiply stages, the
//   bit-per-stage square root, the divide setup stage, the bit-per-stage
//   divider and a final result register. Throughput is one word per cycle,
//   set by the fully pipelined square root and divider.
//   The csr port writes epsilon (index 0) and snap_window (index 1); other
//   indexes are ignored. Write them only while no query is in flight.
//   Synchronous reset empties the pipeline and restores the register defaults.
// ----------------------------------------------------------------------------
module circle_time_of_impact
   import cti_pkg::*;
#(
   parameter int POS_FRAC_BITS  = POS_FRAC_BITS_DEF,
   parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic signed [27:0]    req_ball_x,
   input  logic signed [27:0]    req_ball_y,
   input  logic signed [27:0]    req_ball_vx,
   input  logic signed [27:0]    req_ball_vy,
   input  logic [23:0]           req_ball_radius,
   input  logic signed [27:0]    req_target_x,
   input  logic signed [27:0]    req_target_y,
   input  logic [23:0]           req_target_radius,
   input  logic [31:0]           req_max_time,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_strobe,
   output logic                  rsp_hit,
   output logic [31:0]           rsp_contact_time
);

   localparam int SQ_STEPS = ROOT_W;
   localparam int DV_STEPS = Q_W;
   localparam int LATENCY  = 7 + SQ_STEPS + 1 + DV_STEPS + 1;
   localparam int CMP_W    = A_W + TIME_FRAC_BITS + 2 * POS_FRAC_BITS + 1;
   localparam int DSH      = Q_W - TIME_FRAC_BITS;

   assign busy = 1'b0;

   // Configuration registers.
   logic [CSR_DATA_W-1:0] epsilon_ff, snap_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= EPSILON_RESET;
         snap_ff    <= SNAP_WINDOW_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_EPSILON) epsilon_ff <= csr_wdata;
         if (csr_index == CSR_SNAP_WINDOW) snap_ff <= csr_wdata;
      end
   end

   // Stage 1: relative position and radius sum.
   logic               s1_valid_ff;
   logic signed [28:0] s1_rpx_ff, s1_rpy_ff;
   logic signed [27:0] s1_vx_ff, s1_vy_ff;
   logic [24:0]        s1_sumr_ff;
   logic [31:0]        s1_maxt_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else s1_valid_ff <= start;
      s1_rpx_ff  <= 29'(req_target_x) - 29'(req_ball_x);
      s1_rpy_ff  <= 29'(req_target_y) - 29'(req_ball_y);
      s1_vx_ff   <= req_ball_vx;
      s1_vy_ff   <= req_ball_vy;
      s1_sumr_ff <= 25'(req_ball_radius) + 25'(req_target_radius);
      s1_maxt_ff <= req_max_time;
   end

   // Stage 2: the narrow products.
   logic signed [55:0] vxx_w, vyy_w;
   logic signed [56:0] pxv_in, pyv_in;
   logic signed [57:0] pxx_w, pyy_w;
   logic [49:0]        srr_w;
   always_comb begin
      vxx_w  = s1_vx_ff * s1_vx_ff;
      vyy_w  = s1_vy_ff * s1_vy_ff;
      pxv_in = s1_rpx_ff * s1_vx_ff;
      pyv_in = s1_rpy_ff * s1_vy_ff;
      pxx_w  = s1_rpx_ff * s1_rpx_ff;
      pyy_w  = s1_rpy_ff * s1_rpy_ff;
      srr_w  = s1_sumr_ff * s1_sumr_ff;
   end

   logic               s2_valid_ff;
   logic [54:0]        s2_vxx_ff, s2_vyy_ff;
   logic signed [56:0] s2_pxv_ff, s2_pyv_ff;
   logic [56:0]        s2_pxx_ff, s2_pyy_ff;
   logic [49:0]        s2_srr_ff;
   logic [31:0]        s2_maxt_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else s2_valid_ff <= s1_valid_ff;
      s2_vxx_ff  <= vxx_w[54:0];
      s2_vyy_ff  <= vyy_w[54:0];
      s2_pxv_ff  <= pxv_in;
      s2_pyv_ff  <= pyv_in;
      s2_pxx_ff  <= pxx_w[56:0];
      s2_pyy_ff  <= pyy_w[56:0];
      s2_srr_ff  <= srr_w;
      s2_maxt_ff <= s1_maxt_ff;
   end

   // Stage 3: A, b, |rp|^2 and the early rejects.
   logic [A_W-1:0]     a_in;
   logic signed [57:0] bdot_in;
   logic [CMP_W-1:0]   a_cmp, eps_cmp;
   logic               nohit3_in;
   always_comb begin
      a_in      = A_W'(s2_vxx_ff) + A_W'(s2_vyy_ff);
      bdot_in   = 58'(s2_pxv_ff) + 58'(s2_pyv_ff);
      a_cmp     = CMP_W'(a_in) << TIME_FRAC_BITS;
      eps_cmp   = CMP_W'(epsilon_ff) << (2 * POS_FRAC_BITS);
      nohit3_in = (a_in == '0) || (a_cmp < eps_cmp) || (bdot_in <= 0);
   end

   logic               s3_valid_ff, s3_nohit_ff;
   logic [A_W-1:0]     s3_a_ff;
   logic signed [57:0] s3_bdot_ff;
   logic [57:0]        s3_p2_ff;
   logic [49:0]        s3_s2_ff;
   logic [31:0]        s3_maxt_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else s3_valid_ff <= s2_valid_ff;
      s3_nohit_ff <= nohit3_in;
      s3_a_ff     <= a_in;
      s3_bdot_ff  <= bdot_in;
      s3_p2_ff    <= 58'(s2_pxx_ff) + 58'(s2_pyy_ff);
      s3_s2_ff    <= s2_srr_ff;
      s3_maxt_ff  <= s2_maxt_ff;
   end

   // Stage 4: magnitude of C.
   logic            s4_valid_ff, s4_nohit_ff, s4_dneg_ff;
   logic [A_W-1:0]  s4_a_ff;
   logic [UB_W-1:0] s4_ub_ff;
   logic [D_W-1:0]  s4_d_ff;
   logic [31:0]     s4_maxt_ff;
   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else s4_valid_ff <= s3_valid_ff;
      s4_nohit_ff <= s3_nohit_ff;
      s4_a_ff     <= s3_a_ff;
      s4_ub_ff    <= s3_bdot_ff[UB_W-1:0];
      s4_dneg_ff  <= s3_p2_ff < D_W'(s3_s2_ff);
      s4_d_ff     <= (s3_p2_ff < D_W'(s3_s2_ff)) ? D_W'(s3_s2_ff) - s3_p2_ff
                                                 : s3_p2_ff - D_W'(s3_s2_ff);
      s4_maxt_ff  <= s3_maxt_ff;
   end

   // Stage 5: partial products of b*b and A*|C|.
   logic            s5_valid_ff, s5_nohit_ff, s5_dneg_ff;
   logic [A_W-1:0]  s5_a_ff;
   logic [UB_W-1:0] s5_ub_ff;
   logic [57:0]     s5_ull_ff, s5_ulh_ff;
   logic [55:0]     s5_uhh_ff;
   logic [57:0]     s5_all_ff, s5_alh_ff;
   logic [55:0]     s5_ahl_ff, s5_ahh_ff;
   logic [31:0]     s5_maxt_ff;
   always_ff @(posedge clock) begin
      if (reset) s5_valid_ff <= 1'b0;
      else s5_valid_ff <= s4_valid_ff;
      s5_nohit_ff <= s4_nohit_ff;
      s5_dneg_ff  <= s4_dneg_ff;
      s5_a_ff     <= s4_a_ff;
      s5_ub_ff    <= s4_ub_ff;
      s5_ull_ff   <= 58'(s4_ub_ff[28:0]) * 58'(s4_ub_ff[28:0]);
      s5_ulh_ff   <= 58'(s4_ub_ff[28:0]) * 58'(s4_ub_ff[56:29]);
      s5_uhh_ff   <= 56'(s4_ub_ff[56:29]) * 56'(s4_ub_ff[56:29]);
      s5_all_ff   <= 58'(s4_a_ff[28:0]) * 58'(s4_d_ff[28:0]);
      s5_alh_ff   <= 58'(s4_a_ff[28:0]) * 58'(s4_d_ff[57:29]);
      s5_ahl_ff   <= 56'(s4_a_ff[55:29]) * 56'(s4_d_ff[28:0]);
      s5_ahh_ff   <= 56'(s4_a_ff[55:29]) * 56'(s4_d_ff[57:29]);
      s5_maxt_ff  <= s4_maxt_ff;
   end

   // Stage 6: assemble b*b and A*|C|.
   logic              s6_valid_ff, s6_nohit_ff, s6_dneg_ff;
   logic [A_W-1:0]    s6_a_ff;
   logic [UB_W-1:0]   s6_ub_ff;
   logic [DISC_W-1:0] s6_bb_ff, s6_ac_ff;
   logic [31:0]       s6_maxt_ff;
   always_ff @(posedge clock) begin
      if (reset) s6_valid_ff <= 1'b0;
      else s6_valid_ff <= s5_valid_ff;
      s6_nohit_ff <= s5_nohit_ff;
      s6_dneg_ff  <= s5_dneg_ff;
      s6_a_ff     <= s5_a_ff;
      s6_ub_ff    <= s5_ub_ff;
      s6_bb_ff    <= (DISC_W'(s5_uhh_ff) << 58) + (DISC_W'(s5_ulh_ff) << 30)
                     + DISC_W'(s5_ull_ff);
      s6_ac_ff    <= (DISC_W'(s5_ahh_ff) << 58)
                     + ((DISC_W'(s5_alh_ff) + DISC_W'(s5_ahl_ff)) << 29)
                     + DISC_W'(s5_all_ff);
      s6_maxt_ff  <= s5_maxt_ff;
   end

   // Stage 7: discriminant; it seeds the square root pipeline.
   sq_stage_type sq_ff [0:SQ_STEPS];
   sq_stage_type sq0_in;
   always_comb begin
      sq0_in       = '0;
      sq0_in.valid = s6_valid_ff;
      sq0_in.nohit = s6_nohit_ff || (!s6_dneg_ff && (s6_ac_ff > s6_bb_ff));
      sq0_in.maxt  = s6_maxt_ff;
      sq0_in.ub    = s6_ub_ff;
      sq0_in.a     = s6_a_ff;
      sq0_in.n     = s6_dneg_ff ? s6_bb_ff + s6_ac_ff : s6_bb_ff - s6_ac_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) sq_ff[0] <= '0;
      else sq_ff[0] <= sq0_in;
   end

   // Square root: one result bit per stage, restoring form.
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      sq_stage_type sq_in;
      logic [SREM_W-1:0] r2_w, trial_w;
      always_comb begin
         sq_in   = sq_ff[k];
         r2_w    = {sq_ff[k].rem[SREM_W-3:0], sq_ff[k].n[DISC_W-1 -: 2]};
         trial_w = SREM_W'({sq_ff[k].root, 2'b01});
         if (r2_w >= trial_w) begin
            sq_in.rem  = r2_w - trial_w;
            sq_in.root = {sq_ff[k].root[ROOT_W-2:0], 1'b1};
         end else begin
            sq_in.rem  = r2_w;
            sq_in.root = {sq_ff[k].root[ROOT_W-2:0], 1'b0};
         end
         sq_in.n = sq_ff[k].n << 2;
      end
      always_ff @(posedge clock) begin
         if (reset) sq_ff[k+1] <= '0;
         else sq_ff[k+1] <= sq_in;
      end
   end

   // Divide setup: numerator sign, range check and the first partial remainder.
   sq_stage_type   sq_last;
   dv_stage_type   dv_ff [0:DV_STEPS];
   dv_stage_type   dv0_in;
   logic [D_W-1:0] diff_w;
   logic           neg_w, ovf_w;
   always_comb begin
      sq_last = sq_ff[SQ_STEPS];
      neg_w   = D_W'(sq_last.root) > D_W'(sq_last.ub);
      diff_w  = neg_w ? D_W'(sq_last.root) - D_W'(sq_last.ub)
                      : D_W'(sq_last.ub) - D_W'(sq_last.root);
      ovf_w   = (A_W + Q_W)'(diff_w) >= ((A_W + Q_W)'(sq_last.a) << DSH);
      dv0_in       = '0;
      dv0_in.valid = sq_last.valid;
      dv0_in.nohit = sq_last.nohit || ovf_w;
      dv0_in.neg   = neg_w;
      dv0_in.maxt  = sq_last.maxt;
      dv0_in.a     = sq_last.a;
      dv0_in.rem   = A_W'(diff_w >> DSH);
      dv0_in.lo    = Q_W'({diff_w, {TIME_FRAC_BITS{1'b0}}});
   end
   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= '0;
      else dv_ff[0] <= dv0_in;
   end

   // Divider: one quotient bit per stage, restoring form.
   for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
      dv_stage_type dv_in;
      logic [A_W:0] r2_w;
      always_comb begin
         dv_in = dv_ff[j];
         r2_w  = {dv_ff[j].rem, dv_ff[j].lo[Q_W-1]};
         if (r2_w >= {1'b0, dv_ff[j].a}) begin
            dv_in.rem = A_W'(r2_w - {1'b0, dv_ff[j].a});
            dv_in.q   = {dv_ff[j].q[Q_W-2:0], 1'b1};
         end else begin
            dv_in.rem = A_W'(r2_w);
            dv_in.q   = {dv_ff[j].q[Q_W-2:0], 1'b0};
         end
         dv_in.lo = dv_ff[j].lo << 1;
      end
      always_ff @(posedge clock) begin
         if (reset) dv_ff[j+1] <= '0;
         else dv_ff[j+1] <= dv_in;
      end
   end

   // Final stage: snap window, time limit and saturation.
   dv_stage_type dv_last;
   logic [Q_W:0] ceil_w, limit_w, t_w;
   logic         hit_in;
   logic [31:0]  time_in;
   always_comb begin
      dv_last = dv_ff[DV_STEPS];
      ceil_w  = (Q_W + 1)'(dv_last.q) + (Q_W + 1)'(dv_last.rem != '0);
      limit_w = (Q_W + 1)'(dv_last.maxt) + (Q_W + 1)'(epsilon_ff);
      t_w     = dv_last.neg ? (Q_W + 1)'(epsilon_ff) : (Q_W + 1)'(dv_last.q);
      hit_in  = !dv_last.nohit && (t_w <= limit_w)
                && !(dv_last.neg && (ceil_w >= (Q_W + 1)'(snap_ff)));
      if (!hit_in) time_in = '0;
      else if (t_w > (Q_W + 1)'(32'hFFFF_FFFF)) time_in = 32'hFFFF_FFFF;
      else time_in = t_w[31:0];
   end

   logic        strobe_ff, hit_ff;
   logic [31:0] time_ff;
   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else strobe_ff <= dv_last.valid;
      hit_ff  <= hit_in && dv_last.valid;
      time_ff <= dv_last.valid ? time_in : '0;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_contact_time = time_ff;

   // A hit is only ever shown with its strobe.
   a_hit_strobe: assert property (@(posedge clock) disable iff (reset)
      !rsp_strobe |-> !rsp_hit) else $error("hit without strobe");

   // A miss reports a zero time.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_hit |-> rsp_contact_time == '0) else $error("miss with nonzero time");

   // Every result word traces back to an earlier query, at the depth set by LATENCY.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LATENCY)) else $error("result without query");

endmodule
